### rtl/i2cm_pkg.sv
// i2cm_pkg: phase, stage and status codes for the i2c register access master
// no dependencies
package i2cm_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WAIT_DATA, PH_ST_W, PH_ST_D1, PH_ST_D2, PH_ST_D3,
    PH_RC_W, PH_RC_D1, PH_RC_W2, PH_RC_D2, PH_SP_D1, PH_SP_W, PH_SP_D2, PH_SP_D3,
    PH_WB_D1, PH_WB_W, PH_WB_D2, PH_WB_D3, PH_WA_D1, PH_WA_W, PH_WA_D2, PH_WA_D3,
    PH_RB_D1, PH_RB_W, PH_RB_D2, PH_RB_D3, PH_RA_D1, PH_RA_W, PH_RA_D2, PH_RA_D3
  } phase_t;

  typedef enum logic [2:0] {
    SG_START1, SG_ADDRW, SG_REG, SG_START2, SG_ADDRR, SG_DATA, SG_STOP, SG_INIT
  } stage_t;

  typedef enum logic [2:0] {
    ACT_TICK = 3'd0, ACT_READ = 3'd1, ACT_WRITE = 3'd2, ACT_RECOVER = 3'd3,
    ACT_SUPPLY = 3'd4
  } action_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_NOT_INIT = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_NACK     = 3'd4;
  localparam logic [2:0] ST_STUCK    = 3'd5;

  localparam logic [3:0] RECOVER_PULSES = 4'd9;
  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

  // sequencer state carried between ticks
  typedef struct packed {
    phase_t      phase;
    stage_t      stage;
    logic [3:0]  bit_index;
    logic [15:0] delay_count;
    logic [19:0] stretch_count;
    logic [7:0]  shift_byte;
    logic [15:0] bytes_left;
    logic [3:0]  pulse_count;
    logic [6:0]  saved_address;
    logic [7:0]  saved_register;
    logic        is_read;
    logic [2:0]  pending_status;
    logic        bus_ready;
    logic        scl_low;
    logic        sda_low;
  } seq_state_t;

  // one tick's result
  typedef struct packed {
    logic       done;
    logic       valid;
    logic [2:0] status;
  } seq_event_t;

endpackage

### rtl/i2c_master_register_access.sv
// i2c_master_register_access: top level of the i2c register access master
// depends on i2cm_pkg and i2cm_seq
//
// One input beat is one sequencer tick: it carries an action and the sampled
// SCL/SDA levels, and produces exactly one result beat with the pin drives and
// status after that tick. A beat is taken every clock cycle while in_stall is
// low; the next-state logic sits between the state registers and a one-deep
// output register with a skid slot that hold the results, and a stall on the
// output side only backs up input after the skid slot fills. Register reads and
// writes, clock stretching with timeout and bus recovery (up to nine pulses
// while sda is low, then stop) are handled; a nack or timeout in a transfer
// ends it with a stop, while a timeout in recovery pulses ends it at once. Bus
// timing is set in ticks by half_period_ticks and stretch_timeout_ticks; the
// user must write them via the cfg port while idle; the block does not enforce it.
module i2c_master_register_access (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [6:0]  device_address,
  input  logic [7:0]  register_address,
  input  logic [15:0] byte_count,
  input  logic [7:0]  write_data,
  input  logic        scl_level,
  input  logic        sda_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_pull_low,
  output logic        sda_pull_low,
  output logic        busy_res,
  output logic        done_res,
  output logic [2:0]  status,
  output logic [7:0]  read_data,
  output logic        read_valid,
  output logic        data_request,
  output logic        ready_flag,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [2:0] status;
    logic [7:0] rdata;
    logic       rvalid;
    logic       dreq;
    logic       ready;
  } result_t;

  i2cm_pkg::seq_state_t state, state_next, state_rst;
  i2cm_pkg::seq_event_t ev;
  logic [15:0]          half_period;
  logic [19:0]          stretch_limit;
  result_t              res_new, out_reg, skid_reg;
  logic                 skid_valid;
  logic                 accept;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;

  i2cm_seq u_seq (
    .cur                   (state),
    .action                (action),
    .device_address        (device_address),
    .register_address      (register_address),
    .byte_count            (byte_count),
    .write_data            (write_data),
    .scl_level             (scl_level),
    .sda_level             (sda_level),
    .half_period_ticks     (half_period),
    .stretch_timeout_ticks (stretch_limit),
    .nxt                   (state_next),
    .ev                    (ev)
  );

  // result fields as seen after the tick
  always_comb begin
    res_new.scl    = state_next.scl_low;
    res_new.sda    = state_next.sda_low;
    res_new.busy   = (state_next.phase != i2cm_pkg::PH_IDLE);
    res_new.done   = ev.done;
    res_new.status = ev.done ? ev.status : i2cm_pkg::ST_OK;
    res_new.rdata  = ev.valid ? state_next.shift_byte : 8'd0;
    res_new.rvalid = ev.valid;
    res_new.dreq   = (state_next.phase == i2cm_pkg::PH_WAIT_DATA);
    res_new.ready  = state_next.bus_ready;
  end

  // reset value: idle, start stage, counters and pins clear
  always_comb begin
    state_rst       = '0;
    state_rst.phase = i2cm_pkg::PH_IDLE;
    state_rst.stage = i2cm_pkg::SG_START1;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period   <= 16'd5;
      stretch_limit <= 20'd1000;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) half_period <= cfg_data[15:0];
      else stretch_limit <= cfg_data;
    end
  end

  // sequencer state advances once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= state_rst;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_reg    <= skid_reg;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_reg   <= res_new;
          out_valid <= accept;
        end
      end else if (accept) begin
        skid_reg   <= res_new;
        skid_valid <= 1'b1;
      end
    end
  end

  assign scl_pull_low = out_reg.scl;
  assign sda_pull_low = out_reg.sda;
  assign busy_res     = out_reg.busy;
  assign done_res     = out_reg.done;
  assign status       = out_reg.status;
  assign read_data    = out_reg.rdata;
  assign read_valid   = out_reg.rvalid;
  assign data_request = out_reg.dreq;
  assign ready_flag   = out_reg.ready;

endmodule

### rtl/i2cm_seq.sv
// i2cm_seq: combinational next-state logic of the i2c master sequencer, one tick
// depends on i2cm_pkg
module i2cm_seq (
  input  i2cm_pkg::seq_state_t cur,
  input  logic [2:0]           action,
  input  logic [6:0]           device_address,
  input  logic [7:0]           register_address,
  input  logic [15:0]          byte_count,
  input  logic [7:0]           write_data,
  input  logic                 scl_level,
  input  logic                 sda_level,
  input  logic [15:0]          half_period_ticks,
  input  logic [19:0]          stretch_timeout_ticks,
  output i2cm_pkg::seq_state_t nxt,
  output i2cm_pkg::seq_event_t ev
);

  logic [15:0] delay_load;
  logic [19:0] stretch_inc;
  logic [7:0]  addr_byte;
  logic        is_wait;
  logic [3:0]  bit_inc;
  logic [2:0]  stop_r;

  assign delay_load  = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
  assign stretch_inc = cur.stretch_count + 20'd1;
  assign addr_byte   = {cur.saved_address, 1'b0};
  assign bit_inc     = cur.bit_index + 4'd1;
  assign is_wait = (cur.phase == i2cm_pkg::PH_ST_W) || (cur.phase == i2cm_pkg::PH_RC_W) ||
                   (cur.phase == i2cm_pkg::PH_RC_W2) || (cur.phase == i2cm_pkg::PH_SP_W) ||
                   (cur.phase == i2cm_pkg::PH_WB_W) || (cur.phase == i2cm_pkg::PH_WA_W) ||
                   (cur.phase == i2cm_pkg::PH_RB_W) || (cur.phase == i2cm_pkg::PH_RA_W);
  assign stop_r = (cur.pending_status != i2cm_pkg::ST_OK) ? cur.pending_status :
                  (sda_level ? i2cm_pkg::ST_OK : i2cm_pkg::ST_STUCK);

  always_comb begin
    i2cm_pkg::phase_t tgt;
    logic             do_go;
    logic             do_finish;
    logic [2:0]       fin_code;
    logic             do_fail;
    logic [2:0]       fail_code;
    logic             do_adv;
    logic             wr_begin;
    logic [7:0]       wr_byte;
    logic             rd_begin;

    nxt       = cur;
    ev        = '0;
    tgt       = i2cm_pkg::PH_IDLE;
    do_go     = 1'b0;
    do_finish = 1'b0;
    fin_code  = i2cm_pkg::ST_OK;
    do_fail   = 1'b0;
    fail_code = i2cm_pkg::ST_OK;
    do_adv    = 1'b0;
    wr_begin  = 1'b0;
    wr_byte   = 8'd0;
    rd_begin  = 1'b0;

    if (cur.phase == i2cm_pkg::PH_IDLE) begin
      if (action == i2cm_pkg::ACT_READ || action == i2cm_pkg::ACT_WRITE) begin
        if (byte_count == 16'd0) begin
          do_finish = 1'b1;
          fin_code  = i2cm_pkg::ST_INVALID;
        end else if (!cur.bus_ready) begin
          do_finish = 1'b1;
          fin_code  = i2cm_pkg::ST_NOT_INIT;
        end else begin
          nxt.saved_address  = device_address;
          nxt.saved_register = register_address;
          nxt.bytes_left     = byte_count;
          nxt.is_read        = (action == i2cm_pkg::ACT_READ);
          nxt.pending_status = i2cm_pkg::ST_OK;
          nxt.stage          = i2cm_pkg::SG_START1;
          do_go = 1'b1;
          tgt   = i2cm_pkg::PH_ST_W;
        end
      end else if (action == i2cm_pkg::ACT_RECOVER) begin
        nxt.stage          = i2cm_pkg::SG_INIT;
        nxt.pending_status = i2cm_pkg::ST_OK;
        nxt.pulse_count    = 4'd0;
        do_go = 1'b1;
        tgt   = i2cm_pkg::PH_RC_W;
      end
    end else if (cur.phase == i2cm_pkg::PH_WAIT_DATA) begin
      if (action == i2cm_pkg::ACT_SUPPLY) begin
        wr_begin = 1'b1;
        wr_byte  = write_data;
      end
    end else if (is_wait) begin
      if (scl_level) begin
        do_go = 1'b1;
        case (cur.phase)
          i2cm_pkg::PH_ST_W: begin
            if (sda_level) tgt = i2cm_pkg::PH_ST_D1;
            else begin
              nxt.pulse_count = 4'd0;
              tgt = i2cm_pkg::PH_RC_W;
            end
          end
          i2cm_pkg::PH_RC_W: begin
            tgt = (cur.pulse_count < i2cm_pkg::RECOVER_PULSES && !sda_level) ?
                  i2cm_pkg::PH_RC_D1 : i2cm_pkg::PH_SP_D1;
          end
          i2cm_pkg::PH_RC_W2: tgt = i2cm_pkg::PH_RC_D2;
          i2cm_pkg::PH_SP_W:  tgt = i2cm_pkg::PH_SP_D2;
          i2cm_pkg::PH_WB_W:  tgt = i2cm_pkg::PH_WB_D2;
          i2cm_pkg::PH_WA_W:  tgt = i2cm_pkg::PH_WA_D2;
          i2cm_pkg::PH_RB_W:  tgt = i2cm_pkg::PH_RB_D2;
          default:            tgt = i2cm_pkg::PH_RA_D2;
        endcase
      end else begin
        nxt.stretch_count = stretch_inc;
        if (stretch_inc >= stretch_timeout_ticks) begin
          if (cur.phase == i2cm_pkg::PH_SP_W) begin
            if (cur.pending_status == i2cm_pkg::ST_OK)
              nxt.pending_status = i2cm_pkg::ST_TIMEOUT;
            do_go = 1'b1;
            tgt   = i2cm_pkg::PH_SP_D2;
          end else begin
            do_fail   = 1'b1;
            fail_code = i2cm_pkg::ST_TIMEOUT;
          end
        end
      end
    end else if (cur.delay_count > 16'd1) begin
      nxt.delay_count = cur.delay_count - 16'd1;
    end else begin
      case (cur.phase)
        i2cm_pkg::PH_ST_D1: begin do_go = 1'b1; tgt = i2cm_pkg::PH_ST_D2; end
        i2cm_pkg::PH_ST_D2: begin do_go = 1'b1; tgt = i2cm_pkg::PH_ST_D3; end
        i2cm_pkg::PH_ST_D3: do_adv = 1'b1;
        i2cm_pkg::PH_RC_D1: begin do_go = 1'b1; tgt = i2cm_pkg::PH_RC_W2; end
        i2cm_pkg::PH_RC_D2: begin
          nxt.pulse_count = cur.pulse_count + 4'd1;
          do_go = 1'b1;
          tgt = (nxt.pulse_count < i2cm_pkg::RECOVER_PULSES && !sda_level) ?
                i2cm_pkg::PH_RC_D1 : i2cm_pkg::PH_SP_D1;
        end
        i2cm_pkg::PH_SP_D1: begin do_go = 1'b1; tgt = i2cm_pkg::PH_SP_W; end
        i2cm_pkg::PH_SP_D2: begin do_go = 1'b1; tgt = i2cm_pkg::PH_SP_D3; end
        i2cm_pkg::PH_SP_D3: begin
          if (cur.stage == i2cm_pkg::SG_STOP) begin
            do_finish = 1'b1;
            fin_code  = cur.pending_status;
          end else if (cur.stage == i2cm_pkg::SG_INIT) begin
            nxt.bus_ready = (stop_r == i2cm_pkg::ST_OK);
            do_finish = 1'b1;
            fin_code  = stop_r;
          end else if (stop_r != i2cm_pkg::ST_OK) begin
            nxt.pending_status = stop_r;
            nxt.stage = i2cm_pkg::SG_STOP;
            do_go = 1'b1;
            tgt   = i2cm_pkg::PH_SP_D1;
          end else begin
            do_go = 1'b1;
            tgt   = i2cm_pkg::PH_ST_D1;
          end
        end
        i2cm_pkg::PH_WB_D1: begin do_go = 1'b1; tgt = i2cm_pkg::PH_WB_W; end
        i2cm_pkg::PH_WB_D2: begin do_go = 1'b1; tgt = i2cm_pkg::PH_WB_D3; end
        i2cm_pkg::PH_WB_D3: begin
          nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
          nxt.bit_index  = bit_inc;
          do_go = 1'b1;
          tgt = (bit_inc < i2cm_pkg::BITS_PER_BYTE) ? i2cm_pkg::PH_WB_D1 : i2cm_pkg::PH_WA_D1;
        end
        i2cm_pkg::PH_WA_D1: begin do_go = 1'b1; tgt = i2cm_pkg::PH_WA_W; end
        i2cm_pkg::PH_WA_D2: begin
          nxt.scl_low = 1'b1;
          if (sda_level) begin
            do_fail   = 1'b1;
            fail_code = i2cm_pkg::ST_NACK;
          end else begin
            do_go = 1'b1;
            tgt   = i2cm_pkg::PH_WA_D3;
          end
        end
        i2cm_pkg::PH_WA_D3: begin
          if (cur.stage == i2cm_pkg::SG_DATA && cur.bytes_left != 16'd0)
            nxt.bytes_left = cur.bytes_left - 16'd1;
          do_adv = 1'b1;
        end
        i2cm_pkg::PH_RB_D1: begin do_go = 1'b1; tgt = i2cm_pkg::PH_RB_W; end
        i2cm_pkg::PH_RB_D2: begin
          nxt.shift_byte = {cur.shift_byte[6:0], sda_level};
          do_go = 1'b1;
          tgt   = i2cm_pkg::PH_RB_D3;
        end
        i2cm_pkg::PH_RB_D3: begin
          nxt.bit_index = bit_inc;
          do_go = 1'b1;
          tgt = (bit_inc < i2cm_pkg::BITS_PER_BYTE) ? i2cm_pkg::PH_RB_D1 : i2cm_pkg::PH_RA_D1;
        end
        i2cm_pkg::PH_RA_D1: begin do_go = 1'b1; tgt = i2cm_pkg::PH_RA_W; end
        i2cm_pkg::PH_RA_D2: begin do_go = 1'b1; tgt = i2cm_pkg::PH_RA_D3; end
        default: begin
          ev.valid = 1'b1;
          if (cur.bytes_left != 16'd0) nxt.bytes_left = cur.bytes_left - 16'd1;
          do_adv = 1'b1;
        end
      endcase
    end

    // fail: init aborts at once, a transfer goes to stop
    if (do_fail) begin
      nxt.pending_status = fail_code;
      if (cur.stage == i2cm_pkg::SG_INIT) begin
        nxt.bus_ready = 1'b0;
        do_finish = 1'b1;
        fin_code  = fail_code;
      end else begin
        nxt.stage = i2cm_pkg::SG_STOP;
        do_go = 1'b1;
        tgt   = i2cm_pkg::PH_SP_D1;
      end
    end

    // advance to the next transfer stage
    if (do_adv) begin
      case (cur.stage)
        i2cm_pkg::SG_START1: begin
          nxt.stage = i2cm_pkg::SG_ADDRW; wr_begin = 1'b1; wr_byte = addr_byte;
        end
        i2cm_pkg::SG_ADDRW: begin
          nxt.stage = i2cm_pkg::SG_REG; wr_begin = 1'b1; wr_byte = cur.saved_register;
        end
        i2cm_pkg::SG_REG: begin
          if (cur.is_read) begin
            nxt.stage = i2cm_pkg::SG_START2; do_go = 1'b1; tgt = i2cm_pkg::PH_ST_W;
          end else begin
            nxt.stage = i2cm_pkg::SG_DATA; nxt.phase = i2cm_pkg::PH_WAIT_DATA;
          end
        end
        i2cm_pkg::SG_START2: begin
          nxt.stage = i2cm_pkg::SG_ADDRR; wr_begin = 1'b1; wr_byte = {addr_byte[7:1], 1'b1};
        end
        i2cm_pkg::SG_ADDRR: begin
          nxt.stage = i2cm_pkg::SG_DATA; rd_begin = 1'b1;
        end
        default: begin
          if (nxt.bytes_left != 16'd0) begin
            if (cur.is_read) rd_begin = 1'b1;
            else nxt.phase = i2cm_pkg::PH_WAIT_DATA;
          end else begin
            nxt.stage = i2cm_pkg::SG_STOP; do_go = 1'b1; tgt = i2cm_pkg::PH_SP_D1;
          end
        end
      endcase
    end

    if (wr_begin) begin
      nxt.shift_byte = wr_byte;
      nxt.bit_index  = 4'd0;
      do_go = 1'b1;
      tgt   = i2cm_pkg::PH_WB_D1;
    end
    if (rd_begin) begin
      nxt.shift_byte = 8'd0;
      nxt.bit_index  = 4'd0;
      do_go = 1'b1;
      tgt   = i2cm_pkg::PH_RB_D1;
    end

    // entering a phase sets pins and reloads the timers
    if (do_go) begin
      nxt.phase = tgt;
      case (tgt)
        i2cm_pkg::PH_ST_W, i2cm_pkg::PH_RC_W: begin
          nxt.scl_low = 1'b0; nxt.sda_low = 1'b0;
        end
        i2cm_pkg::PH_ST_D2, i2cm_pkg::PH_SP_D1: nxt.sda_low = 1'b1;
        i2cm_pkg::PH_ST_D3, i2cm_pkg::PH_RC_D1, i2cm_pkg::PH_WB_D3, i2cm_pkg::PH_RB_D3:
          nxt.scl_low = 1'b1;
        i2cm_pkg::PH_RC_W2, i2cm_pkg::PH_SP_W, i2cm_pkg::PH_WB_W, i2cm_pkg::PH_WA_W,
        i2cm_pkg::PH_RB_W, i2cm_pkg::PH_RA_W:
          nxt.scl_low = 1'b0;
        i2cm_pkg::PH_SP_D3, i2cm_pkg::PH_WA_D1, i2cm_pkg::PH_RB_D1: nxt.sda_low = 1'b0;
        i2cm_pkg::PH_WB_D1: nxt.sda_low = ~nxt.shift_byte[7];
        i2cm_pkg::PH_RA_D1: nxt.sda_low = (nxt.bytes_left > 16'd1);
        i2cm_pkg::PH_RA_D3: begin
          nxt.scl_low = 1'b1; nxt.sda_low = 1'b0;
        end
        default: ;
      endcase
      nxt.delay_count   = delay_load;
      nxt.stretch_count = 20'd0;
    end

    if (do_finish) begin
      ev.done   = 1'b1;
      ev.status = fin_code;
      nxt.phase = i2cm_pkg::PH_IDLE;
    end
  end

endmodule
